>>> src/swfpf_pkg.sv
// Shared types, constants and functions for the sync-word frame port filter.
`default_nettype none

package swfpf_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned PORT_W          = 16;
  localparam int unsigned HDR_LEN         = 4;
  localparam int unsigned FRAME_BYTES_DEF = 256;
  localparam int unsigned PORT_OFFSET_DEF = 24;

  localparam logic [BYTE_W-1:0] HDR0 = 8'h11;
  localparam logic [BYTE_W-1:0] HDR1 = 8'h22;
  localparam logic [BYTE_W-1:0] HDR2 = 8'h33;
  localparam logic [BYTE_W-1:0] HDR3 = 8'h44;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] byte_index;
    logic              frame_last;
    logic [PORT_W-1:0] dest_port;
    logic              forward;
  } result_t;

  // Expected header byte at a header position.
  function automatic logic [BYTE_W-1:0] hdr_byte(input logic [1:0] idx);
    logic [BYTE_W-1:0] b;
    case (idx)
      2'd0:    b = HDR0;
      2'd1:    b = HDR1;
      2'd2:    b = HDR2;
      2'd3:    b = HDR3;
      default: b = HDR0;
    endcase
    return b;
  endfunction

  // Ports whose frames are flagged for forwarding.
  function automatic logic port_accepted(input logic [PORT_W-1:0] port);
    return port inside {16'h9002, 16'h7000, 16'h8000,
                        16'h9000, 16'h9100, 16'h9200, 16'h9300,
                        16'h9400, 16'h9500, 16'h9600, 16'h9700,
                        16'h6000, 16'h6100, 16'h6200, 16'h6300, 16'h6400,
                        16'h6600, 16'h6700};
  endfunction

endpackage

`default_nettype wire

>>> src/sync_word_frame_port_filter.sv
// Top level of the sync-word frame port filter.
`default_nettype none

// Takes one received byte per transaction, hunts for the header 11 22 33 44
// and then emits frame bytes 4 to FRAME_BYTES-1 with their (8-bit) index. A
// wrong header byte restarts the hunt and is not itself retried as a first
// header byte. The little-endian port at PORT_OFFSET/PORT_OFFSET+1 is
// captured; the last byte of the frame carries frame_last, the port and the
// forward flag for the accepted port list. One byte is taken every cycle
// while in_stall_o is low; results are held in a result register backed
// by one skid entry, and in_stall_o rises only when both are occupied.
module sync_word_frame_port_filter #(
  parameter int unsigned FRAME_BYTES = swfpf_pkg::FRAME_BYTES_DEF,
  parameter int unsigned PORT_OFFSET = swfpf_pkg::PORT_OFFSET_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [swfpf_pkg::BYTE_W-1:0]  rx_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [swfpf_pkg::BYTE_W-1:0]       data_byte_o,
  output logic [swfpf_pkg::BYTE_W-1:0]       byte_index_o,
  output logic                               frame_last_o,
  output logic [swfpf_pkg::PORT_W-1:0]       dest_port_o,
  output logic                               forward_o
);

  logic               accept;
  logic               res_valid;
  logic               buf_full;
  swfpf_pkg::result_t res;
  swfpf_pkg::result_t out_data;

  assign accept     = in_valid_i && !buf_full;
  assign in_stall_o = buf_full;

  swfpf_framer #(
    .FRAME_BYTES (FRAME_BYTES),
    .PORT_OFFSET (PORT_OFFSET)
  ) u_framer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  swfpf_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign data_byte_o  = out_data.data_byte;
  assign byte_index_o = out_data.byte_index;
  assign frame_last_o = out_data.frame_last;
  assign dest_port_o  = out_data.dest_port;
  assign forward_o    = out_data.forward;

  a_stall_needs_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled while result register empty");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_last_o) |-> byte_index_o == 8'(FRAME_BYTES - 1))
    else $error("frame end flagged at wrong index");

  a_forward_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && forward_o) |-> frame_last_o)
    else $error("forward raised away from frame end");

  a_port_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !frame_last_o) |-> dest_port_o == '0)
    else $error("port shown on a non-final byte");

endmodule

`default_nettype wire

>>> src/swfpf_framer.sv
// Header hunt, frame position counter, port capture and result formation.
`default_nettype none

module swfpf_framer #(
  parameter int unsigned FRAME_BYTES = swfpf_pkg::FRAME_BYTES_DEF,
  parameter int unsigned PORT_OFFSET = swfpf_pkg::PORT_OFFSET_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             accept_i,
  input  wire logic [swfpf_pkg::BYTE_W-1:0]     rx_byte_i,
  output logic                                  res_valid_o,
  output swfpf_pkg::result_t                    res_o
);

  localparam int unsigned POS_W = $clog2(FRAME_BYTES);

  logic [POS_W-1:0]              pos_q, pos_d;
  logic [swfpf_pkg::PORT_W-1:0]  port_q, port_d;
  logic                          in_header;
  logic                          last;

  assign in_header = pos_q < POS_W'(swfpf_pkg::HDR_LEN);
  assign last      = pos_q == POS_W'(FRAME_BYTES - 1);

  always_comb begin
    port_d = port_q;
    if (!in_header && pos_q == POS_W'(PORT_OFFSET)) begin
      port_d[7:0] = rx_byte_i;
    end else if (!in_header && pos_q == POS_W'(PORT_OFFSET + 1)) begin
      port_d[15:8] = rx_byte_i;
    end
  end

  always_comb begin
    if (in_header) begin
      // drop a wrong header byte without testing it again as a first byte
      pos_d = (rx_byte_i == swfpf_pkg::hdr_byte(pos_q[1:0])) ? pos_q + 1'b1 : '0;
    end else if (last) begin
      pos_d = '0;
    end else begin
      pos_d = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      port_q <= '0;
    end else if (accept_i) begin
      pos_q  <= pos_d;
      port_q <= port_d;
    end
  end

  assign res_valid_o        = accept_i && !in_header;
  assign res_o.data_byte    = rx_byte_i;
  assign res_o.byte_index   = 8'(pos_q);
  assign res_o.frame_last   = last;
  assign res_o.dest_port    = last ? port_d : '0;
  assign res_o.forward      = last && swfpf_pkg::port_accepted(port_d);

endmodule

`default_nettype wire

>>> src/swfpf_out_buf.sv
// Result register with a skid entry so the input side takes one more result under stall.
`default_nettype none

module swfpf_out_buf (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire swfpf_pkg::result_t push_data_i,
  output logic                    full_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output swfpf_pkg::result_t      out_data_o
);

  logic               out_valid_q;
  logic               skid_valid_q;
  swfpf_pkg::result_t out_q;
  swfpf_pkg::result_t skid_q;
  logic               pop;

  assign pop = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      // input is stalled: drain the skid entry first
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || pop) begin
      out_valid_q <= push_i;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || pop) begin
      out_q <= push_data_i;
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
